FILE: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, command codes and the command word passed from the
// front end to the executor of the text console cell writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 128;

  localparam int CHAR_W = 8;
  localparam int ROW_FW = 5;
  localparam int COL_FW = 7;

  localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SP = 8'd32;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NL,
    OP_CR,
    OP_BS,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               sel;
    logic [CHAR_W-1:0]  ch;
    logic [ROW_FW-1:0]  rrow;
    logic [COL_FW-1:0]  rcol;
    logic               rd_ok;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Two character-cell consoles (shell and log) with cursor, wrap and scroll.
//
// Input words are pushed while full is low; results are popped while empty
// is low. Each word produces exactly one result, in order. Kind 0 writes a
// byte to the selected console, kind 1 clears the shell console, kind 2
// reads one cell. cfg_we/cfg_wdata write the enable bit; with it low, writes
// and clears leave the consoles untouched.
// A pushed word is registered in the input queue before the executor takes
// it; a plain write, return or backspace then has its result in the output
// register, while a read first passes through the read state.
// Throughput: one plain word per cycle while results are popped at once; a
// read holds the executor until its result is written, a write that scrolls
// while the new bottom row is blanked, a clear while the whole shell memory
// is blanked. After reset both memories are filled with spaces, during which
// full stays high. A stalled result stays in the output register while the
// two-entry input queue keeps taking words.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer import tccw_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        in_kind,
  input  wire logic              in_console_sel,
  input  wire logic [CHAR_W-1:0] in_char_code,
  input  wire logic [ROW_FW-1:0] in_read_row,
  input  wire logic [COL_FW-1:0] in_read_col,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CHAR_W-1:0]      out_cell_char,
  output logic [ROW_FW-1:0]      out_pos_row,
  output logic [COL_FW-1:0]      out_pos_col,
  output logic                   out_scrolled
);

  logic enable_r, enable_nxt;
  logic cmd_valid, cmd_pop, init_busy;
  cmd_t cmd;

  assign enable_nxt = cfg_we ? cfg_wdata : enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  tccw_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_console_sel (in_console_sel),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .hold           (init_busy),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd)
  );

  tccw_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .enable         (enable_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .init_busy      (init_busy),
    .empty          (empty),
    .pop            (pop),
    .out_cell_char  (out_cell_char),
    .out_pos_row    (out_pos_row),
    .out_pos_col    (out_pos_col),
    .out_scrolled   (out_scrolled)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Input side: decodes each word into a command and holds it in a two-entry
// queue until the executor takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front import tccw_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        in_kind,
  input  wire logic              in_console_sel,
  input  wire logic [CHAR_W-1:0] in_char_code,
  input  wire logic [ROW_FW-1:0] in_read_row,
  input  wire logic [COL_FW-1:0] in_read_col,
  input  wire logic              hold,
  output logic                   cmd_valid,
  input  wire logic              cmd_pop,
  output cmd_t                   cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       acc;
  logic       take;

  always_comb begin
    dec.sel   = in_console_sel;
    dec.ch    = in_char_code;
    dec.rrow  = in_read_row;
    dec.rcol  = in_read_col;
    dec.rd_ok = ({2'b00, in_read_row} < 7'(ROWS)) && ({2'b00, in_read_col} < 9'(COLS));
    case (in_kind)
      KIND_PUT: begin
        case (in_char_code)
          CH_NL:   dec.op = OP_NL;
          CH_CR:   dec.op = OP_CR;
          CH_BS:   dec.op = OP_BS;
          default: dec.op = OP_CHAR;
        endcase
      end
      KIND_CLEAR: dec.op = OP_CLEAR;
      KIND_READ:  dec.op = OP_READ;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2) || hold;
  assign acc       = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign take      = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = acc ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(acc) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (acc) begin
      q_r[wp_r] <= dec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != 2'd0)
    else $error("command popped from empty queue");
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $past(cnt_r) >= cnt_r)
    else $error("queue grew while held");

endmodule

`default_nettype wire

FILE: hw/rtl/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Executor: owns both cell memories, cursors and scroll offsets, runs the
// reset, scroll and clear sweeps, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back import tccw_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              enable,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  output logic                   init_busy,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CHAR_W-1:0]      out_cell_char,
  output logic [ROW_FW-1:0]      out_pos_row,
  output logic [COL_FW-1:0]      out_pos_col,
  output logic                   out_scrolled
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_BLANK, S_CLEAR} state_t;

  state_t            state_r, state_nxt;
  logic [RW-1:0]     row_r [2], row_nxt [2];
  logic [CW-1:0]     col_r [2], col_nxt [2];
  logic [RW-1:0]     top_r [2], top_nxt [2];
  logic [AW-1:0]     walk_r, walk_nxt;
  logic              wsel_r, wsel_nxt;
  logic [RW-1:0]     brow_r, brow_nxt;
  logic              rsel_r, rsel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [ROW_FW-1:0] out_row_r, out_row_nxt;
  logic [COL_FW-1:0] out_col_r, out_col_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic              we_sh, we_lg, re_sh, re_lg;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wdata, rd_sh, rd_lg;

  logic              sel;
  logic [RW-1:0]     cur_row, cur_top, prow, new_row;
  logic [CW-1:0]     cur_col, new_col;
  logic              adv, scroll;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    walk_nxt      = walk_r;
    wsel_nxt      = wsel_r;
    brow_nxt      = brow_r;
    rsel_nxt      = rsel_r;
    out_valid_nxt = out_valid_r && !pop;
    out_char_nxt  = out_char_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    cmd_pop       = 1'b0;
    we_sh         = 1'b0;
    we_lg         = 1'b0;
    re_sh         = 1'b0;
    re_lg         = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = CH_SP;
    sel           = (cmd.op == OP_CLEAR) ? 1'b0 : cmd.sel;
    cur_row       = row_r[sel];
    cur_col       = col_r[sel];
    cur_top       = top_r[sel];
    prow          = phys_row(cur_row, cur_top);
    new_row       = cur_row;
    new_col       = cur_col;
    adv           = 1'b0;
    scroll        = 1'b0;

    case (state_r)
      S_INIT: begin
        we_sh    = 1'b1;
        we_lg    = 1'b1;
        waddr    = walk_r;
        walk_nxt = walk_r + AW'(1);
        if (walk_r == AW'(DEPTH - 1)) begin
          walk_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        we_sh    = 1'b1;
        waddr    = walk_r;
        walk_nxt = walk_r + AW'(1);
        if (walk_r == AW'(DEPTH - 1)) begin
          walk_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_BLANK: begin
        we_sh    = !wsel_r;
        we_lg    = wsel_r;
        waddr    = {brow_r, walk_r[CW-1:0]};
        walk_nxt = walk_r + AW'(1);
        if (walk_r[CW-1:0] == CW'(COLS - 1)) begin
          walk_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rsel_r ? rd_lg : rd_sh;
        out_row_nxt   = ROW_FW'(row_r[rsel_r]);
        out_col_nxt   = COL_FW'(col_r[rsel_r]);
        out_scr_nxt   = 1'b0;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid && (!out_valid_r || pop)) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_CHAR: begin
              if (enable) begin
                we_sh = !sel;
                we_lg = sel;
                waddr = {prow, cur_col};
                wdata = cmd.ch;
                if (cur_col == CW'(COLS - 1)) begin
                  new_col = '0;
                  adv     = 1'b1;
                end else begin
                  new_col = cur_col + CW'(1);
                end
              end
            end
            OP_NL: begin
              if (enable) begin
                new_col = '0;
                adv     = 1'b1;
              end
            end
            OP_CR: begin
              if (enable) begin
                new_col = '0;
              end
            end
            OP_BS: begin
              if (enable && cur_col != '0) begin
                new_col = cur_col - CW'(1);
                we_sh   = !sel;
                we_lg   = sel;
                waddr   = {prow, cur_col - CW'(1)};
              end
            end
            OP_CLEAR: begin
              if (enable) begin
                new_row    = '0;
                new_col    = '0;
                top_nxt[0] = '0;
                walk_nxt   = '0;
                state_nxt  = S_CLEAR;
              end
            end
            OP_READ: begin
              if (cmd.rd_ok) begin
                re_sh     = !sel;
                re_lg     = sel;
                raddr     = {phys_row(RW'(cmd.rrow), cur_top), CW'(cmd.rcol)};
                rsel_nxt  = sel;
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
          if (adv) begin
            if (cur_row == RW'(ROWS - 1)) begin
              scroll        = 1'b1;
              top_nxt[sel]  = (cur_top == RW'(ROWS - 1)) ? '0 : cur_top + RW'(1);
              brow_nxt      = cur_top;
              wsel_nxt      = sel;
              walk_nxt      = '0;
              state_nxt     = S_BLANK;
            end else begin
              new_row = cur_row + RW'(1);
            end
          end
          row_nxt[sel] = new_row;
          col_nxt[sel] = new_col;
          if (!(cmd.op == OP_READ && cmd.rd_ok)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = '0;
            out_row_nxt   = ROW_FW'(new_row);
            out_col_nxt   = COL_FW'(new_col);
            out_scr_nxt   = scroll;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      row_r       <= '{default: '0};
      col_r       <= '{default: '0};
      top_r       <= '{default: '0};
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wsel_r     <= wsel_nxt;
    brow_r     <= brow_nxt;
    rsel_r     <= rsel_nxt;
    out_char_r <= out_char_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  tccw_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_shell_ram (
    .clk   (clk),
    .we    (we_sh),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_sh),
    .raddr (raddr),
    .rdata (rd_sh)
  );

  tccw_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (we_lg),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_lg),
    .raddr (raddr),
    .rdata (rd_lg)
  );

  assign init_busy     = (state_r == S_INIT);
  assign empty         = !out_valid_r;
  assign out_cell_char = out_char_r;
  assign out_pos_row   = out_row_r;
  assign out_pos_col   = out_col_r;
  assign out_scrolled  = out_scr_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r[0]} < (CW+1)'(COLS)) && ({1'b0, col_r[1]} < (CW+1)'(COLS)))
    else $error("cursor column beyond grid");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r[0]} < (RW+1)'(ROWS)) && ({1'b0, row_r[1]} < (RW+1)'(ROWS)) &&
    ({1'b0, top_r[0]} < (RW+1)'(ROWS)) && ({1'b0, top_r[1]} < (RW+1)'(ROWS)))
    else $error("cursor row or scroll offset beyond grid");
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && (!out_valid_r || pop))
    else $error("command taken without a free result slot");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("read finished without a result");

endmodule

`default_nettype wire
